FILE: design/motor_tuning_command_parser_assert.svh
// Assertion macros shared by the checker of the motor tuning command parser.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef MOTOR_TUNING_COMMAND_PARSER_ASSERT_SVH
`define MOTOR_TUNING_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mtcp_pkg.sv
// Shared types, codes and constants of the motor tuning command parser.
// No dependencies; used by every module of the block.
package mtcp_pkg;

    localparam int MOTOR_COUNT     = 4;
    localparam int FRACTION_DIGITS = 4;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int MOTOR_W = 3;
    localparam int SEL_W   = 2;
    localparam int INDEX_W = 3;
    localparam int MAG_W   = 47;
    localparam int VALUE_W = 48;
    localparam int FRAC_W  = 3;
    localparam int FC_DEPTH = 8;
    localparam int SCALE_W = 21;
    localparam int CFG_ADDR_W = 1;
    localparam int OUT_DATA_W = 56;

    localparam longint unsigned MAG_MAX = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_NEG_MAX = 48'h8000_0000_0001;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_START_CHAR = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_END_CHAR   = 1'd1;

    localparam logic [BYTE_W-1:0] START_CHAR_RESET = 8'h23;
    localparam logic [BYTE_W-1:0] END_CHAR_RESET   = 8'h21;

    localparam logic [BYTE_W-1:0] CH_EQUALS = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
    localparam logic [BYTE_W-1:0] CH_V      = 8'h56;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_FOUR   = 8'h34;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

    localparam logic [KIND_W-1:0] KIND_MOTOR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PARAM   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd2;

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_START = 8'b0000_0010,
        PH_GROUP = 8'b0000_0100,
        PH_SEEK  = 8'b0000_1000,
        PH_VSIGN = 8'b0001_0000,
        PH_VINT  = 8'b0010_0000,
        PH_VFRAC = 8'b0100_0000,
        PH_MOTOR = 8'b1000_0000
    } phase_t;

    // Everything the output stage needs to build one result.
    typedef struct packed {
        logic                 valid;
        logic [KIND_W-1:0]    kind;
        logic [MOTOR_W-1:0]   motor;
        logic                 loop_group;
        logic [INDEX_W-1:0]   param_index;
        logic                 negative;
        logic [MAG_W-1:0]     magnitude;
        logic [FRAC_W-1:0]    frac_count;
        logic                 clipped;
    } emit_req_t;

    function automatic longint unsigned pow10(input int unsigned n);
        longint unsigned p;
        p = 1;
        for (int unsigned i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

endpackage

FILE: design/mtcp_parser.sv
// Packet state machine and value accumulator of the motor tuning command parser.
// Depends on mtcp_pkg; feeds result requests to mtcp_out.
module mtcp_parser
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mtcp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mtcp_pkg::BYTE_W-1:0]         cfg_wdata,
    input  logic                                byte_fire,
    input  logic [mtcp_pkg::BYTE_W-1:0]         rx_byte,
    output mtcp_pkg::emit_req_t                 emit_req
);

    localparam int MW = mtcp_pkg::MAG_W;

    mtcp_pkg::phase_t                   phase_reg, phase_next;
    logic [mtcp_pkg::BYTE_W-1:0]        start_char_reg;
    logic [mtcp_pkg::BYTE_W-1:0]        end_char_reg;
    logic [mtcp_pkg::SEL_W-1:0]         sel_motor_reg, sel_motor_next;
    logic [mtcp_pkg::BYTE_W-1:0]        motor_acc_reg, motor_acc_next;
    logic [mtcp_pkg::BYTE_W-1:0]        group_reg, group_next;
    logic [mtcp_pkg::BYTE_W-1:0]        index_reg, index_next;
    logic                               neg_reg, neg_next;
    logic [MW-1:0]                      mag_reg, mag_next;
    logic [mtcp_pkg::FRAC_W-1:0]        frac_reg, frac_next;
    logic                               clip_reg, clip_next;

    logic                               is_digit;
    logic [3:0]                         digit;
    logic [MW+3:0]                      push_sum;
    logic                               push_over;
    logic [MW-1:0]                      push_mag;
    logic [8:0]                         acc_sum;
    logic                               group_ok;
    logic                               index_ok;
    logic                               acc_ok;
    logic [mtcp_pkg::SEL_W-1:0]         acc_sel;

    assign is_digit = (rx_byte >= mtcp_pkg::CH_ZERO) && (rx_byte <= mtcp_pkg::CH_NINE);
    assign digit    = rx_byte[3:0];

    // magnitude * 10 + digit; anything above 47 bits means the magnitude clips.
    assign push_sum  = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0}
                     + {{MW{1'b0}}, digit};
    assign push_over = (push_sum[MW+3:MW] != 4'd0);
    assign push_mag  = push_over ? {MW{1'b1}} : push_sum[MW-1:0];

    assign acc_sum  = {motor_acc_reg[5:0], 3'b000} + {motor_acc_reg[7:0], 1'b0}
                    + {5'd0, digit};

    assign group_ok = (group_reg == mtcp_pkg::CH_P) || (group_reg == mtcp_pkg::CH_V);
    assign index_ok = (index_reg >= mtcp_pkg::CH_ZERO) && (index_reg <= mtcp_pkg::CH_FOUR);
    assign acc_ok   = (motor_acc_reg != 8'd0)
                    && (motor_acc_reg <= 8'(mtcp_pkg::MOTOR_COUNT));
    assign acc_sel  = acc_ok ? mtcp_pkg::SEL_W'(motor_acc_reg - 8'd1) : '0;

    always_comb
    begin
        phase_next     = phase_reg;
        sel_motor_next = sel_motor_reg;
        motor_acc_next = motor_acc_reg;
        group_next     = group_reg;
        index_next     = index_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        frac_next      = frac_reg;
        clip_next      = clip_reg;

        emit_req             = '0;
        emit_req.motor       = {1'b0, sel_motor_reg} + 3'd1;
        emit_req.negative    = neg_reg;
        emit_req.magnitude   = mag_reg;
        emit_req.frac_count  = frac_reg;
        emit_req.clipped     = clip_reg;

        if (byte_fire) begin
            if (rx_byte == start_char_reg) begin
                // A second start right after the first opens a motor select.
                if (phase_reg == mtcp_pkg::PH_START) begin
                    motor_acc_next = '0;
                    phase_next     = mtcp_pkg::PH_MOTOR;
                end
                else begin
                    phase_next = mtcp_pkg::PH_START;
                end
            end
            else begin
                unique case (phase_reg)
                    mtcp_pkg::PH_IDLE:
                    begin
                        phase_next = mtcp_pkg::PH_IDLE;
                    end
                    mtcp_pkg::PH_START:
                    begin
                        if (rx_byte == end_char_reg) begin
                            phase_next = mtcp_pkg::PH_IDLE;
                        end
                        else begin
                            group_next = rx_byte;
                            phase_next = mtcp_pkg::PH_GROUP;
                        end
                    end
                    mtcp_pkg::PH_GROUP, mtcp_pkg::PH_SEEK:
                    begin
                        if (rx_byte == end_char_reg) begin
                            phase_next = mtcp_pkg::PH_IDLE;
                        end
                        else begin
                            if (phase_reg == mtcp_pkg::PH_GROUP) begin
                                index_next = rx_byte;
                                phase_next = mtcp_pkg::PH_SEEK;
                            end
                            if (rx_byte == mtcp_pkg::CH_EQUALS) begin
                                neg_next   = 1'b0;
                                mag_next   = '0;
                                frac_next  = '0;
                                clip_next  = 1'b0;
                                phase_next = mtcp_pkg::PH_VSIGN;
                            end
                        end
                    end
                    mtcp_pkg::PH_VSIGN, mtcp_pkg::PH_VINT, mtcp_pkg::PH_VFRAC:
                    begin
                        if (rx_byte == end_char_reg) begin
                            emit_req.valid = 1'b1;
                            if (group_ok && index_ok) begin
                                emit_req.kind        = mtcp_pkg::KIND_PARAM;
                                emit_req.loop_group  = (group_reg == mtcp_pkg::CH_V);
                                emit_req.param_index = index_reg[2:0];
                            end
                            else begin
                                emit_req.kind = mtcp_pkg::KIND_UNKNOWN;
                            end
                            phase_next = mtcp_pkg::PH_IDLE;
                        end
                        else if (phase_reg == mtcp_pkg::PH_VSIGN
                                 && rx_byte == mtcp_pkg::CH_MINUS) begin
                            neg_next   = 1'b1;
                            phase_next = mtcp_pkg::PH_VINT;
                        end
                        else if (is_digit) begin
                            if (phase_reg == mtcp_pkg::PH_VFRAC) begin
                                // Fraction digits past the kept count are dropped.
                                if (frac_reg < mtcp_pkg::FRAC_W'(mtcp_pkg::FRACTION_DIGITS))
                                begin
                                    mag_next  = push_mag;
                                    clip_next = clip_reg | push_over;
                                    frac_next = frac_reg + 3'd1;
                                end
                            end
                            else begin
                                mag_next   = push_mag;
                                clip_next  = clip_reg | push_over;
                                phase_next = mtcp_pkg::PH_VINT;
                            end
                        end
                        else if (rx_byte == mtcp_pkg::CH_DOT) begin
                            phase_next = mtcp_pkg::PH_VFRAC;
                        end
                        else if (phase_reg == mtcp_pkg::PH_VSIGN) begin
                            phase_next = mtcp_pkg::PH_VINT;
                        end
                    end
                    mtcp_pkg::PH_MOTOR:
                    begin
                        if (rx_byte == end_char_reg) begin
                            sel_motor_next      = acc_sel;
                            emit_req.valid      = 1'b1;
                            emit_req.kind       = mtcp_pkg::KIND_MOTOR;
                            emit_req.motor      = {1'b0, acc_sel} + 3'd1;
                            emit_req.negative   = 1'b0;
                            emit_req.magnitude  = '0;
                            emit_req.clipped    = 1'b0;
                            phase_next          = mtcp_pkg::PH_IDLE;
                        end
                        else if (is_digit) begin
                            // The number saturates at 255, which never names a motor.
                            if (motor_acc_reg > 8'd25 || acc_sum > 9'd255) begin
                                motor_acc_next = 8'd255;
                            end
                            else begin
                                motor_acc_next = acc_sum[7:0];
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = mtcp_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_char_reg <= mtcp_pkg::START_CHAR_RESET;
            end_char_reg   <= mtcp_pkg::END_CHAR_RESET;
        end
        else if (cfg_we) begin
            unique case (cfg_addr)
                mtcp_pkg::REG_START_CHAR: start_char_reg <= cfg_wdata;
                mtcp_pkg::REG_END_CHAR:   end_char_reg   <= cfg_wdata;
                default:                  start_char_reg <= start_char_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= mtcp_pkg::PH_IDLE;
            sel_motor_reg <= '0;
            motor_acc_reg <= '0;
            group_reg     <= '0;
            index_reg     <= '0;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            frac_reg      <= '0;
            clip_reg      <= 1'b0;
        end
        else begin
            phase_reg     <= phase_next;
            sel_motor_reg <= sel_motor_next;
            motor_acc_reg <= motor_acc_next;
            group_reg     <= group_next;
            index_reg     <= index_next;
            neg_reg       <= neg_next;
            mag_reg       <= mag_next;
            frac_reg      <= frac_next;
            clip_reg      <= clip_next;
        end
    end

endmodule

FILE: design/mtcp_out.sv
// Result stage of the motor tuning command parser: fraction padding, sign,
// saturation and the output register. Depends on mtcp_pkg.
module mtcp_out
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  mtcp_pkg::emit_req_t                 emit_req,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [mtcp_pkg::KIND_W-1:0]         kind,
    output logic [mtcp_pkg::MOTOR_W-1:0]        motor,
    output logic                                loop_group,
    output logic [mtcp_pkg::INDEX_W-1:0]        param_index,
    output logic [mtcp_pkg::VALUE_W-1:0]        value,
    output logic                                saturated
);

    localparam int SW = mtcp_pkg::SCALE_W;
    localparam int MW = mtcp_pkg::MAG_W;

    logic signed [SW-1:0]       scale_pos_tab [mtcp_pkg::FC_DEPTH];
    logic signed [SW-1:0]       scale_neg_tab [mtcp_pkg::FC_DEPTH];
    logic [MW-1:0]              limit_tab     [mtcp_pkg::FC_DEPTH];

    // Padding to the full fraction count multiplies by 10^(digits missing).
    for (genvar i = 0; i < mtcp_pkg::FC_DEPTH; i++) begin : g_scale
        localparam int unsigned PadDigits =
            (i <= mtcp_pkg::FRACTION_DIGITS) ? (mtcp_pkg::FRACTION_DIGITS - i) : 0;
        localparam longint unsigned Scale = mtcp_pkg::pow10(PadDigits);
        localparam longint unsigned Limit = mtcp_pkg::MAG_MAX / Scale;
        localparam longint NegScale = -longint'(Scale);
        assign scale_pos_tab[i] = SW'(Scale);
        assign scale_neg_tab[i] = SW'(NegScale);
        assign limit_tab[i]     = MW'(Limit);
    end

    logic signed [SW-1:0]       scale_sel;
    logic signed [MW+SW:0]      product;
    logic                       pad_over;
    logic [mtcp_pkg::VALUE_W-1:0] value_next;
    logic                       valid_reg;
    logic [mtcp_pkg::KIND_W-1:0]  kind_reg;
    logic [mtcp_pkg::MOTOR_W-1:0] motor_reg;
    logic                       group_reg;
    logic [mtcp_pkg::INDEX_W-1:0] index_reg;
    logic [mtcp_pkg::VALUE_W-1:0] value_reg;
    logic                       sat_reg;

    // The sign rides on the scale constant so a single multiply gives the value.
    assign scale_sel = emit_req.negative ? scale_neg_tab[emit_req.frac_count]
                                         : scale_pos_tab[emit_req.frac_count];
    assign product   = $signed({1'b0, emit_req.magnitude}) * scale_sel;
    assign pad_over  = emit_req.magnitude > limit_tab[emit_req.frac_count];

    always_comb
    begin
        if (pad_over) begin
            value_next = emit_req.negative ? mtcp_pkg::VALUE_NEG_MAX
                                           : mtcp_pkg::VALUE_POS_MAX;
        end
        else begin
            value_next = product[mtcp_pkg::VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (emit_req.valid) begin
            valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_req.valid) begin
            kind_reg  <= emit_req.kind;
            motor_reg <= emit_req.motor;
            group_reg <= emit_req.loop_group;
            index_reg <= emit_req.param_index;
            value_reg <= value_next;
            sat_reg   <= emit_req.clipped | pad_over;
        end
    end

    assign out_valid   = valid_reg;
    assign kind        = kind_reg;
    assign motor       = motor_reg;
    assign loop_group  = group_reg;
    assign param_index = index_reg;
    assign value       = value_reg;
    assign saturated   = sat_reg;

endmodule

FILE: design/motor_tuning_command_parser.sv
// Top level of the motor tuning command parser.
// Depends on mtcp_pkg, mtcp_parser and mtcp_out.
//
// Usage:
// Received serial bytes enter on the s_axis channel, one byte per request.
// Two packet kinds are recognized: "##n!" selects motor n, and
// "#Gk=[-]ddd.dddd!" sets parameter k of loop group G. Each closing byte of a
// complete packet produces one result on the m_axis channel; every other byte
// produces none. The start and end bytes can be changed through the write
// port (index 0 start, index 1 end) while the block is idle.
// Throughput is one byte per cycle while the receiver does not stall; the state
// machine updates in the cycle a byte is taken. A result shows up in the cycle
// after its closing byte is taken, from a single output register that also holds
// the padded, signed and saturated value.
// When the receiver stalls, the pending result holds and s_axis_tready drops
// until the result is taken; if the receiver takes it in the same cycle a new
// byte is accepted alongside. Reset returns the parser to idle, selects motor
// one, restores the default delimiters and empties the output register.
module motor_tuning_command_parser
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mtcp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mtcp_pkg::BYTE_W-1:0]         cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mtcp_pkg::BYTE_W-1:0]         s_axis_tdata,   // [7:0] rx_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] motor, [3] loop_group, [6:4] param_index, [54:7] value, [55] saturated
    output logic [mtcp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic [mtcp_pkg::KIND_W-1:0]         m_axis_tuser    // [1:0] kind
);

    mtcp_pkg::emit_req_t                emit_req;
    logic                               byte_fire;
    logic [mtcp_pkg::MOTOR_W-1:0]       motor;
    logic                               loop_group;
    logic [mtcp_pkg::INDEX_W-1:0]       param_index;
    logic [mtcp_pkg::VALUE_W-1:0]       value;
    logic                               saturated;

    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign byte_fire     = s_axis_tvalid && s_axis_tready;

    mtcp_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .byte_fire (byte_fire),
        .rx_byte   (s_axis_tdata),
        .emit_req  (emit_req)
    );

    mtcp_out u_out
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .emit_req    (emit_req),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .kind        (m_axis_tuser),
        .motor       (motor),
        .loop_group  (loop_group),
        .param_index (param_index),
        .value       (value),
        .saturated   (saturated)
    );

    assign m_axis_tdata = {saturated, value, param_index, loop_group, motor};

endmodule

FILE: design/mtcp_checker.sv
// Port-level checker of the motor tuning command parser, bound to the top level.
// Depends on mtcp_pkg and motor_tuning_command_parser_assert.svh.
`include "motor_tuning_command_parser_assert.svh"

module mtcp_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [mtcp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic [mtcp_pkg::KIND_W-1:0]         m_axis_tuser
);

    `MTCP_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // Input side only waits while a result is pending and not being taken.
    `MTCP_ASSERT_NOW(a_ready_rule, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output register")

    `MTCP_ASSERT_NOW(a_motor_range, m_axis_tvalid, (m_axis_tdata[2:0] != 3'd0) && (m_axis_tdata[2:0] <= 3'(mtcp_pkg::MOTOR_COUNT)), "motor number out of range")

    `MTCP_ASSERT_NOW(a_motor_clean, m_axis_tvalid && (m_axis_tuser == mtcp_pkg::KIND_MOTOR), m_axis_tdata[55:3] == 53'd0, "motor select carries parameter data")

    `MTCP_ASSERT_NOW(a_unknown_clean, m_axis_tvalid && (m_axis_tuser == mtcp_pkg::KIND_UNKNOWN), m_axis_tdata[6:3] == 4'd0, "unknown packet carries group or index")

endmodule

bind motor_tuning_command_parser mtcp_checker u_checker (.*);
